// ===== hdl/fwpid_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fwpid_pkg;

	localparam int MAX_WHEELS      = 4;
	localparam int WHEEL_COUNT_DEF = 4;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int IN_DATA_W   = 160;
	localparam int OUT_DATA_W  = 40;

	// register indexes of the config port
	localparam logic [CFG_INDEX_W-1:0] REG_KP_GAINS    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KI_GAINS    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_KD_GAINS    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PULSE_SCALE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_PWM_LIMIT   = 3'd4;

	localparam logic [7:0] PWM_LIMIT_RST = 8'd150;

	// wheel direction, 2-bit signed
	localparam logic [1:0] DIR_ZERO = 2'b00;
	localparam logic [1:0] DIR_POS  = 2'b01;
	localparam logic [1:0] DIR_NEG  = 2'b11;

	typedef struct packed {
		logic [63:0] kp_gains;
		logic [63:0] ki_gains;
		logic [63:0] kd_gains;
		logic [31:0] pulse_scale;
		logic [7:0]  pwm_limit;
	} cfg_t;

	typedef struct packed {
		logic [MAX_WHEELS-1:0][23:0] speed_cmd;
		logic [MAX_WHEELS-1:0][15:0] pulses;
	} item_t;

	typedef struct packed {
		logic [MAX_WHEELS-1:0][1:0] dir;
		logic [MAX_WHEELS-1:0][7:0] pwm;
	} result_t;

	typedef struct packed {
		logic start;
		logic out_free;
	} ctl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} sts_t;

endpackage

`default_nettype wire

// ===== hdl/fwpid_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fwpid_core #(
	parameter int WHEEL_COUNT = fwpid_pkg::WHEEL_COUNT_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  fwpid_pkg::cfg_t     cfg,
	input  fwpid_pkg::ctl_t     ctl,
	input  fwpid_pkg::item_t    item,
	output fwpid_pkg::sts_t     sts,
	output fwpid_pkg::result_t  res
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SPD  = 4'd1;
	localparam logic [3:0] S_ERR  = 4'd2;
	localparam logic [3:0] S_INT  = 4'd3;
	localparam logic [3:0] S_KP   = 4'd4;
	localparam logic [3:0] S_KI   = 4'd5;
	localparam logic [3:0] S_KD   = 4'd6;
	localparam logic [3:0] S_FIN  = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	localparam logic [1:0] LAST_WHEEL = 2'(WHEEL_COUNT - 1);

	logic [3:0]              state_q;
	logic [1:0]              w_q;
	fwpid_pkg::item_t        item_q;
	fwpid_pkg::result_t      res_q;

	logic signed [49:0]      prod_q;
	logic signed [24:0]      err_q;
	logic signed [31:0]      integ_q;
	logic signed [25:0]      der_q;
	logic signed [50:0]      sum_q;

	logic signed [31:0]      acc_q  [fwpid_pkg::MAX_WHEELS];
	logic signed [24:0]      last_q [fwpid_pkg::MAX_WHEELS];

	// shared multiplier operands
	logic signed [32:0]      mul_a;
	logic signed [16:0]      mul_b;

	logic [15:0]             pul_w;
	logic [23:0]             cmd_w;
	logic [15:0]             kp_w;
	logic [15:0]             ki_w;
	logic [15:0]             kd_w;

	logic signed [49:0]      raw_adj;
	logic signed [49:0]      meas_full;
	logic signed [23:0]      meas;
	logic signed [24:0]      err_calc;
	logic signed [32:0]      isum;
	logic signed [31:0]      integ_calc;
	logic signed [25:0]      der_calc;
	logic signed [50:0]      prod_ext;
	logic [50:0]             sum_mag;
	logic [34:0]             pwm_full;
	logic [7:0]              pwm_calc;
	logic [1:0]              dir_calc;

	assign pul_w = item_q.pulses[w_q];
	assign cmd_w = item_q.speed_cmd[w_q];
	assign kp_w  = cfg.kp_gains[w_q*16 +: 16];
	assign ki_w  = cfg.ki_gains[w_q*16 +: 16];
	assign kd_w  = cfg.kd_gains[w_q*16 +: 16];

	always_comb begin
		case (state_q)
			S_SPD: begin
				mul_a = $signed({1'b0, cfg.pulse_scale});
				mul_b = $signed({pul_w[15], pul_w});
			end
			S_INT: begin
				mul_a = $signed({{8{err_q[24]}}, err_q});
				mul_b = $signed({1'b0, kp_w});
			end
			S_KP: begin
				mul_a = $signed({integ_q[31], integ_q});
				mul_b = $signed({1'b0, ki_w});
			end
			S_KI: begin
				mul_a = $signed({{7{der_q[25]}}, der_q});
				mul_b = $signed({1'b0, kd_w});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// truncate toward zero: bias negative products before the shift
	always_comb begin
		raw_adj   = prod_q + (prod_q[49] ? 50'sd255 : 50'sd0);
		meas_full = raw_adj >>> 8;
		if (meas_full > 50'sd8388607) begin
			meas = 24'sh7FFFFF;
		end else if (meas_full < -50'sd8388608) begin
			meas = 24'sh800000;
		end else begin
			meas = meas_full[23:0];
		end
		err_calc = $signed({cmd_w[23], cmd_w}) - $signed({meas[23], meas});
	end

	always_comb begin
		isum = $signed({acc_q[w_q][31], acc_q[w_q]}) + $signed({{8{err_q[24]}}, err_q});
		if (isum[32] != isum[31]) begin
			integ_calc = isum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
		end else begin
			integ_calc = isum[31:0];
		end
		der_calc = $signed({err_q[24], err_q}) - $signed({last_q[w_q][24], last_q[w_q]});
	end

	assign prod_ext = {prod_q[49], prod_q};

	always_comb begin
		sum_mag  = sum_q[50] ? 51'(-sum_q) : 51'(sum_q);
		pwm_full = sum_mag[50:16];
		if ((|pwm_full[34:8]) || (pwm_full[7:0] > cfg.pwm_limit)) begin
			pwm_calc = cfg.pwm_limit;
		end else begin
			pwm_calc = pwm_full[7:0];
		end
		if (sum_q == '0) begin
			dir_calc = fwpid_pkg::DIR_ZERO;
		end else if (sum_q[50]) begin
			dir_calc = fwpid_pkg::DIR_NEG;
		end else begin
			dir_calc = fwpid_pkg::DIR_POS;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (ctl.start) begin
			item_q <= item;
		end
		if (state_q == S_ERR) begin
			err_q <= err_calc;
		end
		if (state_q == S_INT) begin
			integ_q <= integ_calc;
			der_q   <= der_calc;
		end
		case (state_q)
			S_KP:    sum_q <= prod_ext;
			S_KI:    sum_q <= sum_q + prod_ext;
			S_KD:    sum_q <= sum_q + prod_ext;
			default: sum_q <= sum_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			w_q     <= '0;
			res_q   <= '0;
			for (int i = 0; i < fwpid_pkg::MAX_WHEELS; i++) begin
				acc_q[i]  <= '0;
				last_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (ctl.start) begin
						state_q <= S_SPD;
						w_q     <= '0;
						res_q   <= '0;
					end
				end
				S_SPD: state_q <= S_ERR;
				S_ERR: state_q <= S_INT;
				S_INT: begin
					acc_q[w_q]  <= integ_calc;
					last_q[w_q] <= err_q;
					state_q     <= S_KP;
				end
				S_KP: state_q <= S_KI;
				S_KI: state_q <= S_KD;
				S_KD: state_q <= S_FIN;
				S_FIN: begin
					res_q.pwm[w_q] <= pwm_calc;
					res_q.dir[w_q] <= dir_calc;
					if (w_q == LAST_WHEEL) begin
						state_q <= S_DONE;
					end else begin
						w_q     <= 2'(w_q + 2'd1);
						state_q <= S_SPD;
					end
				end
				S_DONE: begin
					if (ctl.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sts.idle = (state_q == S_IDLE);
	assign sts.done = (state_q == S_DONE) && ctl.out_free;
	assign res      = res_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> state_q == S_IDLE)
		else $error("item start while sequencer busy");

	a_start_wheel0: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> (state_q == S_SPD && w_q == 2'd0))
		else $error("sequencer did not begin at wheel 0");

	a_wheel_range: assert property (@(posedge clk) disable iff (!arst_n)
		w_q <= LAST_WHEEL)
		else $error("wheel index past configured count");

	a_zero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && sum_q == '0) |->
			(pwm_calc == 8'd0 && dir_calc == fwpid_pkg::DIR_ZERO))
		else $error("zero pid sum gave nonzero drive");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |=> state_q == S_IDLE)
		else $error("sequencer not idle after result handoff");

endmodule

`default_nettype wire

// ===== hdl/four_wheel_pid_speed_control.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tdata: pulses w0..w3, speed_cmd w0..w3
// m_*      out  m_tvalid/m_tready  m_tdata: pwm w0..w3, dir w0..w3
// cfg_*    in   cfg_we             cfg_index, cfg_wdata
//
// each wheel steps through the states SPD, ERR, INT, KP, KI, KD and FIN on the shared
// 33x17 multiplier, and the item ends in the handoff state DONE
// s_tready is high only while the sequencer is idle
// the finished beat sits in an output register; the sequencer waits in its handoff
// step only when that register is still full
// reset clears config (pwm_limit to 150), integrals, last errors and control

module four_wheel_pid_speed_control #(
	parameter int WHEEL_COUNT = fwpid_pkg::WHEEL_COUNT_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   s_tvalid,
	output logic                                  s_tready,
	// pulses_w0..w3 (16 each), speed_cmd_w0..w3 (24 each)
	input  wire  [fwpid_pkg::IN_DATA_W-1:0]       s_tdata,
	output logic                                  m_tvalid,
	input  wire                                   m_tready,
	// pwm_w0..w3 (8 each), dir_w0..w3 (2 each)
	output logic [fwpid_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  wire                                   cfg_we,
	input  wire  [fwpid_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire  [fwpid_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	fwpid_pkg::cfg_t     cfg_q;
	fwpid_pkg::ctl_t     ctl;
	fwpid_pkg::sts_t     sts;
	fwpid_pkg::item_t    item;
	fwpid_pkg::result_t  res;
	fwpid_pkg::result_t  out_q;
	logic                m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_gains    <= '0;
			cfg_q.ki_gains    <= '0;
			cfg_q.kd_gains    <= '0;
			cfg_q.pulse_scale <= '0;
			cfg_q.pwm_limit   <= fwpid_pkg::PWM_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				fwpid_pkg::REG_KP_GAINS:    cfg_q.kp_gains    <= cfg_wdata;
				fwpid_pkg::REG_KI_GAINS:    cfg_q.ki_gains    <= cfg_wdata;
				fwpid_pkg::REG_KD_GAINS:    cfg_q.kd_gains    <= cfg_wdata;
				fwpid_pkg::REG_PULSE_SCALE: cfg_q.pulse_scale <= cfg_wdata[31:0];
				fwpid_pkg::REG_PWM_LIMIT:   cfg_q.pwm_limit   <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign item.pulses    = s_tdata[63:0];
	assign item.speed_cmd = s_tdata[159:64];

	assign s_tready     = sts.idle;
	assign ctl.start    = s_tvalid && sts.idle;
	assign ctl.out_free = !m_tvalid_q || m_tready;

	fwpid_core #(
		.WHEEL_COUNT (WHEEL_COUNT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.ctl    (ctl),
		.item   (item),
		.sts    (sts),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (sts.done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sts.done) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

endmodule

`default_nettype wire
